### rtl/mwvsf_pkg.sv
// Package for the memory word value scan filter.
// Holds register codes, lane-size and mode enums, and the per-byte compare flag type.
// No dependencies.
package mwvsf_pkg;

   localparam int WordW   = 64;
   localparam int ByteW   = 8;
   localparam int NumBytes = WordW / ByteW;
   localparam int ByteIdxW = $clog2(NumBytes);
   localparam int CsrIdxW = 4;

   localparam logic [CsrIdxW-1:0] CSR_VALUE_LOW   = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_VALUE_HIGH  = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_LANE_SIZE   = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_SEARCH_MODE = 4'd3;

   typedef enum logic [1:0] {
      LANE_8  = 2'd0,
      LANE_16 = 2'd1,
      LANE_32 = 2'd2,
      LANE_64 = 2'd3
   } lane_size_type;

   typedef enum logic {
      MODE_EQUAL = 1'b0,
      MODE_RANGE = 1'b1
   } search_mode_type;

   typedef struct packed {
      logic eq_lo;
      logic gt_lo;
      logic eq_hi;
      logic lt_hi;
   } cmp_flags_type;

   // upper part decides unless equal, then the lower part decides
   function automatic cmp_flags_type combine_flags(cmp_flags_type upper, cmp_flags_type lower);
      cmp_flags_type f;
      f.eq_lo = upper.eq_lo & lower.eq_lo;
      f.gt_lo = upper.gt_lo | (upper.eq_lo & lower.gt_lo);
      f.eq_hi = upper.eq_hi & lower.eq_hi;
      f.lt_hi = upper.lt_hi | (upper.eq_hi & lower.lt_hi);
      return f;
   endfunction

   function automatic logic lane_hit(cmp_flags_type f, search_mode_type mode);
      logic hit;
      unique case (mode)
         MODE_RANGE: hit = (f.gt_lo | f.eq_lo) & (f.lt_hi | f.eq_hi);
         MODE_EQUAL: hit = f.eq_lo;
         default:    hit = 1'b0;
      endcase
      return hit;
   endfunction

   // byte offset mask within a lane: selects the value byte each data byte meets
   function automatic logic [ByteIdxW-1:0] byte_sel_mask(lane_size_type size);
      logic [ByteIdxW-1:0] m;
      unique case (size)
         LANE_8:  m = 3'd0;
         LANE_16: m = 3'd1;
         LANE_32: m = 3'd3;
         LANE_64: m = 3'd7;
         default: m = 3'd0;
      endcase
      return m;
   endfunction

endpackage

### rtl/mwvsf_byte_cmp.sv
// One byte lane comparator: data byte against the low and high value bytes.
// Depends on mwvsf_pkg.
module mwvsf_byte_cmp
   import mwvsf_pkg::*;
(
   input  logic [ByteW-1:0] data_byte,
   input  logic [ByteW-1:0] low_byte,
   input  logic [ByteW-1:0] high_byte,
   output cmp_flags_type    flags
);

   always_comb begin
      flags.eq_lo = (data_byte == low_byte);
      flags.gt_lo = (data_byte >  low_byte);
      flags.eq_hi = (data_byte == high_byte);
      flags.lt_hi = (data_byte <  high_byte);
   end

endmodule

### rtl/mwvsf_merge.sv
// Merges byte compare flags into 16/32/64-bit lanes and reduces to one hit.
// Depends on mwvsf_pkg.
module mwvsf_merge
   import mwvsf_pkg::*;
(
   input  cmp_flags_type   byte_flags [NumBytes],
   input  lane_size_type   lane_size,
   input  search_mode_type search_mode,
   output logic            hit
);

   cmp_flags_type f16 [4];
   cmp_flags_type f32 [2];
   cmp_flags_type f64;
   logic [7:0]    h8;
   logic [3:0]    h16;
   logic [1:0]    h32;
   logic          h64;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         f16[i] = combine_flags(byte_flags[2*i+1], byte_flags[2*i]);
      end
      for (int i = 0; i < 2; i++) begin
         f32[i] = combine_flags(f16[2*i+1], f16[2*i]);
      end
      f64 = combine_flags(f32[1], f32[0]);
      for (int i = 0; i < 8; i++) begin
         h8[i] = lane_hit(byte_flags[i], search_mode);
      end
      for (int i = 0; i < 4; i++) begin
         h16[i] = lane_hit(f16[i], search_mode);
      end
      for (int i = 0; i < 2; i++) begin
         h32[i] = lane_hit(f32[i], search_mode);
      end
      h64 = lane_hit(f64, search_mode);
   end

   always_comb begin
      unique case (lane_size)
         LANE_8:  hit = |h8;
         LANE_16: hit = |h16;
         LANE_32: hit = |h32;
         LANE_64: hit = h64;
         default: hit = 1'b0;
      endcase
   end

endmodule

### rtl/memory_word_value_scan_filter.sv
// Top level of the memory word value scan filter: config registers, byte lanes, merge, output.
// Depends on mwvsf_pkg, mwvsf_byte_cmp and mwvsf_merge.
//
//   channel | ports                                  | dir | beat
//   req     | req_valid/ready, word_address/data     | in  | one 64-bit word + address
//   rsp     | rsp_valid/ready, hit_address/hit_word  | out | one hitting word
//   csr     | csr_wr_en, csr_index, csr_wdata        | in  | one register write
//
// Byte compares are registered in the s1 stage, then the lane merge result is registered in the output stage.
// One word per cycle sustained while rsp is not stalled; a word with no hit produces no beat.
// Stalls on rsp back up through the compare stage to req_ready.
// Synchronous reset clears config registers and valid flags.
module memory_word_value_scan_filter
   import mwvsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [WordW-1:0]   req_word_address,
   input  logic [WordW-1:0]   req_word_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [WordW-1:0]   rsp_hit_address,
   output logic [WordW-1:0]   rsp_hit_word,
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [WordW-1:0]   csr_wdata
);

   logic [WordW-1:0]    value_low_ff, value_low_in;
   logic [WordW-1:0]    value_high_ff, value_high_in;
   lane_size_type       lane_size_ff, lane_size_in;
   search_mode_type     search_mode_ff, search_mode_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [WordW-1:0]    s1_addr_ff, s1_addr_in;
   logic [WordW-1:0]    s1_data_ff, s1_data_in;
   cmp_flags_type       s1_flags_ff [NumBytes];
   cmp_flags_type       s1_flags_in [NumBytes];

   logic                out_valid_ff, out_valid_in;
   logic [WordW-1:0]    out_addr_ff, out_addr_in;
   logic [WordW-1:0]    out_word_ff, out_word_in;

   logic                [ByteIdxW-1:0] sel_mask;
   logic                s1_hit;
   logic                out_free;
   logic                s1_advance;
   logic                req_take;

   // config writes
   always_comb begin
      value_low_in   = value_low_ff;
      value_high_in  = value_high_ff;
      lane_size_in   = lane_size_ff;
      search_mode_in = search_mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VALUE_LOW:   value_low_in   = csr_wdata;
            CSR_VALUE_HIGH:  value_high_in  = csr_wdata;
            CSR_LANE_SIZE:   lane_size_in   = lane_size_type'(csr_wdata[1:0]);
            CSR_SEARCH_MODE: search_mode_in = search_mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   assign sel_mask = byte_sel_mask(lane_size_ff);

   for (genvar b = 0; b < NumBytes; b++) begin : g_lane
      localparam logic [ByteIdxW-1:0] ByteIdx = ByteIdxW'(b);
      logic [ByteIdxW-1:0] vsel;
      assign vsel = ByteIdx & sel_mask;
      mwvsf_byte_cmp u_cmp (
         .data_byte (req_word_data[b*ByteW +: ByteW]),
         .low_byte  (value_low_ff[vsel*ByteW +: ByteW]),
         .high_byte (value_high_ff[vsel*ByteW +: ByteW]),
         .flags     (s1_flags_in[b])
      );
   end

   mwvsf_merge u_merge (
      .byte_flags  (s1_flags_ff),
      .lane_size   (lane_size_ff),
      .search_mode (search_mode_ff),
      .hit         (s1_hit)
   );

   // handshake
   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_addr_in   = req_take ? req_word_address : s1_addr_ff;
      s1_data_in   = req_take ? req_word_data : s1_data_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_addr_in  = out_addr_ff;
      out_word_in  = out_word_ff;
      if (s1_advance && s1_hit) begin
         out_valid_in = 1'b1;
         out_addr_in  = s1_addr_ff;
         out_word_in  = s1_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_low_ff   <= '0;
         value_high_ff  <= '0;
         lane_size_ff   <= LANE_8;
         search_mode_ff <= MODE_EQUAL;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         value_low_ff   <= value_low_in;
         value_high_ff  <= value_high_in;
         lane_size_ff   <= lane_size_in;
         search_mode_ff <= search_mode_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_data_ff  <= s1_data_in;
      out_addr_ff <= out_addr_in;
      out_word_ff <= out_word_in;
      if (req_take) begin
         s1_flags_ff <= s1_flags_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit_address = out_addr_ff;
   assign rsp_hit_word    = out_word_ff;

endmodule

### verif/mwvsf_checker.sv
// Scan filter checker: watches the csr, req and rsp ports of the block and keeps its own
// copy of the filter settings to predict which words come back as hits.
// Depends on mwvsf_pkg for register codes and the lane-size and mode enums.
module mwvsf_checker
   import mwvsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [WordW-1:0]   req_word_address,
   input  logic [WordW-1:0]   req_word_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [WordW-1:0]   rsp_hit_address,
   input  logic [WordW-1:0]   rsp_hit_word,
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [WordW-1:0]   csr_wdata,
   output int                 fail_count,
   output int                 pending_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WordW-1:0] address;
      logic [WordW-1:0] word;
   } scan_hit_type;

   logic [WordW-1:0] filter_low;
   logic [WordW-1:0] filter_high;
   lane_size_type    filter_size;
   search_mode_type  filter_mode;
   scan_hit_type     hit_queue[$];

   function automatic bit word_has_hit(logic [WordW-1:0] word);
      int unsigned      bits;
      int unsigned      lanes;
      logic [WordW-1:0] mask;
      logic [WordW-1:0] lo;
      logic [WordW-1:0] hi;
      logic [WordW-1:0] lane;
      bit               hit;
      bits  = 8 << filter_size;
      lanes = WordW / bits;
      mask  = {WordW{1'b1}} >> (WordW - bits);
      lo    = filter_low & mask;
      hi    = filter_high & mask;
      hit   = 1'b0;
      for (int k = 0; k < lanes; k++) begin
         lane = (word >> (k * bits)) & mask;
         if (filter_mode == MODE_RANGE) begin
            hit |= (lane >= lo) && (lane <= hi);
         end else begin
            hit |= (lane == lo);
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      scan_hit_type seen;
      scan_hit_type want;
      if (reset) begin
         filter_low  = '0;
         filter_high = '0;
         filter_size = LANE_8;
         filter_mode = MODE_EQUAL;
         hit_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VALUE_LOW:   filter_low  = csr_wdata;
               CSR_VALUE_HIGH:  filter_high = csr_wdata;
               CSR_LANE_SIZE:   filter_size = lane_size_type'(csr_wdata[1:0]);
               CSR_SEARCH_MODE: filter_mode = search_mode_type'(csr_wdata[0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready && word_has_hit(req_word_data)) begin
            hit_queue.push_back({req_word_address, req_word_data});
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_hit_address, rsp_hit_word};
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected rsp beat, address %h word %h",
                        $time, seen.address, seen.word);
               fail_count++;
            end else begin
               want = hit_queue.pop_front();
               if (seen.address !== want.address) begin
                  $display("%0t: hit_address expected %h actual %h",
                           $time, want.address, seen.address);
                  fail_count++;
               end
               if (seen.word !== want.word) begin
                  $display("%0t: hit_word expected %h actual %h",
                           $time, want.word, seen.word);
                  fail_count++;
               end
            end
         end
      end
      pending_hits = hit_queue.size();
   end

endmodule

### verif/tb_memory_word_value_scan_filter.sv
// Testbench top for the memory word value scan filter: clock, reset, csr programming,
// word stimulus, rsp backpressure, watchdog and verdict.
// Depends on mwvsf_pkg, mwvsf_checker and the block itself.
module tb_memory_word_value_scan_filter;
   import mwvsf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit    = 2000;
   localparam int HoldOffCycles = 200;
   localparam int PhaseWords    = 150;
   localparam int NumPhases     = 12;
   localparam int DrainCycles   = 6;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [WordW-1:0]   req_word_address;
   logic [WordW-1:0]   req_word_data;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [WordW-1:0]   rsp_hit_address;
   logic [WordW-1:0]   rsp_hit_word;
   logic               csr_wr_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [WordW-1:0]   csr_wdata;
   int                 fail_count;
   int                 pending_hits;
   bit                 idle_enabled;
   int unsigned        holdoff_requests;
   int                 quiet_cycles;

   memory_word_value_scan_filter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word_address (req_word_address),
      .req_word_data    (req_word_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit_address  (rsp_hit_address),
      .rsp_hit_word     (rsp_hit_word),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   mwvsf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word_address (req_word_address),
      .req_word_data    (req_word_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit_address  (rsp_hit_address),
      .rsp_hit_word     (rsp_hit_word),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_hits     (pending_hits)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // rsp side: random stalls, plus one long hold-off on request
   initial begin : rsp_driver
      int unsigned served;
      served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests != served) begin
            served = holdoff_requests;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_ready <= !(idle_enabled && $urandom_range(0, 99) < 19);
         end
      end
   end

   task automatic send_word(logic [WordW-1:0] address, logic [WordW-1:0] data);
      while (idle_enabled && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_word_address <= address;
      req_word_data    <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] index, logic [WordW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // waits for the pipeline to drain, then rewrites every register
   task automatic program_filter(logic [WordW-1:0] low, logic [WordW-1:0] high,
                                 lane_size_type size, search_mode_type mode);
      logic [WordW-1:0] noise;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      noise = {$urandom, $urandom};
      write_csr(CsrIdxW'($urandom_range(int'(CSR_SEARCH_MODE) + 1, (1 << CsrIdxW) - 1)),
                {$urandom, $urandom});
      write_csr(CSR_VALUE_LOW, low);
      write_csr(CSR_VALUE_HIGH, high);
      write_csr(CSR_LANE_SIZE, {noise[WordW-1:2], size});
      write_csr(CSR_SEARCH_MODE, {noise[WordW-1:1], mode});
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [WordW-1:0] low;
      logic [WordW-1:0] high;
      logic [WordW-1:0] mask;
      logic [WordW-1:0] lane;
      logic [WordW-1:0] word;
      logic [WordW-1:0] address;
      lane_size_type    size;
      search_mode_type  mode;
      int unsigned      bits;

      idle_enabled     = 1'b1;
      holdoff_requests = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_word_address <= '0;
      req_word_data    <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_VALUE_LOW;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // settings after reset: byte lanes, equal to zero
      send_word(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0000_0000_0000_0008, 64'h00FF_FFFF_FFFF_FFFF);
      send_word(64'h0000_0000_0000_0010, 64'h0101_0101_0101_0101);

      // full range on one 64-bit lane; misaligned address passes through
      program_filter(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, LANE_64, MODE_RANGE);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      send_word(64'h0000_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFFF);

      // empty range once truncated to 16 bits
      program_filter(64'hAAAA_0000_0000_0005, 64'h5555_0000_0000_0003, LANE_16, MODE_RANGE);
      send_word(64'h0000_0000_0000_0018, 64'h0004_0004_0004_0004);
      send_word(64'h0000_0000_0000_0020, 64'h0003_0005_0000_FFFF);

      // target truncated to 32 bits, hit only in the upper lane
      program_filter(64'hDEAD_BEEF_1234_5678, 64'h0, LANE_32, MODE_EQUAL);
      send_word(64'h0000_0000_0000_0028, 64'h1234_5678_0000_0000);
      send_word(64'h0000_0000_0000_0030, 64'hDEAD_BEEF_0000_0000);

      program_filter(64'h10, 64'h10, LANE_8, MODE_RANGE);
      send_word(64'h0000_0000_0000_0038, 64'h0000_0000_1000_0000);
      send_word(64'h0000_0000_0000_0040, 64'h0F11_0F11_0F11_0F11);

      program_filter(64'h0, 64'hFFFF_FFFF, LANE_32, MODE_RANGE);
      send_word(64'h0000_0000_0000_0048, 64'h8000_0000_7FFF_FFFF);

      program_filter(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, LANE_64, MODE_EQUAL);
      send_word(64'h0000_0000_0000_0050, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0000_0000_0000_0058, 64'hFFFF_FFFF_FFFF_FFFE);

      for (int phase = 0; phase < NumPhases; phase++) begin
         size = lane_size_type'(phase % 4);
         if (phase < 4) begin
            mode = MODE_EQUAL;
         end else if (phase < 8) begin
            mode = MODE_RANGE;
         end else begin
            mode = search_mode_type'($urandom_range(0, 1));
         end
         bits = 8 << size;
         mask = {WordW{1'b1}} >> (WordW - bits);
         low  = {$urandom, $urandom};
         high = {$urandom, $urandom};
         if (((low & mask) > (high & mask)) && $urandom_range(0, 3) != 0) begin
            {low, high} = {high, low};
         end
         if (phase == 3) low = '1;
         if (phase == 4) begin
            low  = '0;
            high = '1;
         end
         if (phase == 6) high = low;
         if (phase == 8) low = '0;
         idle_enabled = (phase != 2) && (phase != 9);
         program_filter(low, high, size, mode);

         for (int n = 0; n < PhaseWords; n++) begin
            if (phase == 5 && n == 20) holdoff_requests++;
            if ($urandom_range(0, 99) < 15) begin
               word = {$urandom, $urandom};
            end else begin
               word = '0;
               for (int k = 0; k < WordW / bits; k++) begin
                  case ($urandom_range(0, 7))
                     0, 1:    lane = low;
                     2:       lane = high;
                     3:       lane = low - 1;
                     4:       lane = high + 1;
                     default: lane = {$urandom, $urandom};
                  endcase
                  word |= (lane & mask) << (k * bits);
               end
            end
            address = {$urandom, $urandom};
            if ($urandom_range(0, 1) != 0) address[2:0] = '0;
            send_word(address, word);
         end
      end

      idle_enabled = 1'b1;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_hits == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
